[rtl/core/ihc_pkg.sv]
// Package for the IPv4/TCP/UDP header checker: header state and verdict types,
// protocol codes and stream widths. No dependencies.
`default_nettype none

package ihc_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 176;

   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [3:0]  IP_VERSION_4  = 4'd4;
   localparam logic [15:0] CHECKSUM_WORD = 16'd10;
   localparam logic [15:0] MIN_IP_BYTES  = 16'd20;
   localparam logic [5:0]  MIN_TCP_BYTES = 6'd20;
   localparam logic [5:0]  UDP_HDR_BYTES = 6'd8;
   localparam logic [15:0] TP_FIELD_BYTES = 16'd14;

   // Header fields gathered while a packet streams in.
   typedef struct packed {
      logic [7:0]  byte0;
      logic [15:0] total_len;
      logic [15:0] frag;
      logic [7:0]  proto;
      logic [15:0] checksum;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] seq;
      logic [7:0]  tcp_off;
      logic [7:0]  tcp_flags;
      logic [20:0] sum;
      logic [7:0]  hold;
   } hdr_state_type;

   // Verdict fields, the last member in the lowest bits.
   typedef struct packed {
      logic [31:0] tcp_sequence;
      logic [3:0]  tcp_flag_bits;
      logic        is_fragment;
      logic [15:0] dest_port;
      logic [15:0] source_port;
      logic [31:0] dest_address;
      logic [31:0] source_address;
      logic [15:0] packet_bytes;
      logic [5:0]  transport_header_bytes;
      logic [5:0]  ip_header_bytes;
      logic [7:0]  protocol_number;
      logic        packet_ok;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/ihc_verdict.sv]
// Verdict logic of the header checker: checks the gathered IPv4 and TCP/UDP
// header fields of one packet and forms the result. Depends on ihc_pkg.
`default_nettype none

module ihc_verdict (
   input  ihc_pkg::hdr_state_type state,
   input  logic [15:0]            length,
   output ihc_pkg::result_type    result
);
   import ihc_pkg::*;

   always_comb begin
      logic [5:0]  hdr;
      logic [5:0]  thdr;
      logic [16:0] fold1;
      logic [15:0] fold2;
      logic [15:0] size;
      logic [15:0] ulen;
      logic [16:0] udp_end;
      logic        ok;

      result = '0;
      hdr = {state.byte0[3:0], 2'b00};
      thdr = {state.tcp_off[7:4], 2'b00};
      ulen = state.seq[31:16];
      udp_end = 17'(hdr) + 17'(ulen);
      fold1 = 17'(state.sum[15:0]) + 17'(state.sum[20:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);
      size = (state.total_len < length) ? state.total_len : length;

      ok = (length >= MIN_IP_BYTES) && (state.byte0[7:4] == IP_VERSION_4)
         && (hdr != 6'd0) && (16'(hdr) <= length)
         && (state.checksum == (fold2 ^ 16'hFFFF));

      if (state.proto == PROTO_TCP) begin
         ok = ok && (17'(size) >= 17'(hdr) + 17'(MIN_TCP_BYTES))
            && (17'(size) >= 17'(hdr) + 17'(thdr)) && (thdr >= MIN_TCP_BYTES);
         result.transport_header_bytes = thdr;
         result.source_port = state.sport;
         result.dest_port = state.dport;
         result.tcp_sequence = state.seq;
         result.tcp_flag_bits = {state.tcp_flags[4], state.tcp_flags[2],
                                 state.tcp_flags[1], state.tcp_flags[0]};
         result.packet_bytes = size;
      end else if (state.proto == PROTO_UDP) begin
         ok = ok && (17'(size) >= 17'(hdr) + 17'(UDP_HDR_BYTES))
            && (17'(size) >= udp_end);
         result.transport_header_bytes = UDP_HDR_BYTES;
         result.source_port = state.sport;
         result.dest_port = state.dport;
         result.packet_bytes = udp_end[15:0];
      end else begin
         result.packet_bytes = size;
      end

      result.packet_ok = 1'b1;
      result.protocol_number = state.proto;
      result.ip_header_bytes = hdr;
      result.source_address = state.src;
      result.dest_address = state.dst;
      result.is_fragment = state.frag[13] || (state.frag[12:0] != 13'd0);

      if (!ok) begin
         result = '0;
      end
   end

endmodule

`default_nettype wire

[rtl/core/ipv4_tcp_udp_header_checker.sv]
// Top level of the IPv4/TCP/UDP header checker: byte input stage, header
// gathering, verdict snapshot and result register. Depends on ihc_pkg, ihc_verdict.
`default_nettype none

// The block takes an IPv4 packet as a stream of byte transactions, one byte
// per cycle sustained, with req_tlast on the final byte, and returns one
// verdict transaction per packet. The per-byte work is a single pass over an
// input register: header bytes are captured into fixed fields and the
// checksum word sum is updated, so a byte can follow in every cycle. The
// verdict for a packet is registered onto rsp after its last byte is
// accepted and is held until taken; the next packet streams in meanwhile,
// and req_tready falls only when a further last byte meets a full snapshot
// and result register. Header bytes at or past CAPTURE_BYTES read as zero.
module ipv4_tcp_udp_header_checker #(
   parameter int CAPTURE_BYTES = 80
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ihc_pkg::REQ_TDATA_W-1:0] req_tdata,  // data_byte[7:0]
   input  logic                            req_tlast,  // last_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // packet_ok[0], protocol_number[8:1], ip_header_bytes[14:9],
   // transport_header_bytes[20:15], packet_bytes[36:21], source_address[68:37],
   // dest_address[100:69], source_port[116:101], dest_port[132:117],
   // is_fragment[133], tcp_flag_bits[137:134], tcp_sequence[169:138], zeros above.
   output logic [ihc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ihc_pkg::*;

   logic          a_valid_ff;
   logic [7:0]    a_byte_ff;
   logic          a_last_ff;
   logic [15:0]   idx_ff;
   logic [15:0]   idx_in;
   hdr_state_type act_ff;
   hdr_state_type act_in;
   logic          snap_valid_ff;
   hdr_state_type snap_ff;
   logic [15:0]   snap_len_ff;
   logic          out_valid_ff;
   result_type    out_ff;
   result_type    verdict;

   logic        out_free;
   logic        snap_free;
   logic        a_adv;
   logic [5:0]  hdr_cur;
   logic [15:0] rel;
   logic [15:0] word_at;

   assign out_free = !out_valid_ff || rsp_tready;
   assign snap_free = !snap_valid_ff || out_free;
   assign a_adv = a_valid_ff && (!a_last_ff || snap_free);
   assign req_tready = !a_valid_ff || a_adv;

   assign hdr_cur = {act_ff.byte0[3:0], 2'b00};
   assign rel = idx_ff - 16'(hdr_cur);
   assign word_at = idx_ff - 16'd1;
   assign idx_in = (&idx_ff) ? idx_ff : idx_ff + 16'd1;

   always_comb begin
      act_in = act_ff;
      unique case (idx_ff)
         16'd0:   act_in.byte0 = a_byte_ff;
         16'd2:   act_in.total_len[15:8] = a_byte_ff;
         16'd3:   act_in.total_len[7:0] = a_byte_ff;
         16'd6:   act_in.frag[15:8] = a_byte_ff;
         16'd7:   act_in.frag[7:0] = a_byte_ff;
         16'd9:   act_in.proto = a_byte_ff;
         16'd10:  act_in.checksum[15:8] = a_byte_ff;
         16'd11:  act_in.checksum[7:0] = a_byte_ff;
         16'd12:  act_in.src[31:24] = a_byte_ff;
         16'd13:  act_in.src[23:16] = a_byte_ff;
         16'd14:  act_in.src[15:8] = a_byte_ff;
         16'd15:  act_in.src[7:0] = a_byte_ff;
         16'd16:  act_in.dst[31:24] = a_byte_ff;
         16'd17:  act_in.dst[23:16] = a_byte_ff;
         16'd18:  act_in.dst[15:8] = a_byte_ff;
         16'd19:  act_in.dst[7:0] = a_byte_ff;
         default: ;
      endcase

      if ((idx_ff != 16'd0) && (idx_ff >= 16'(hdr_cur)) && (rel < TP_FIELD_BYTES)
          && (idx_ff < 16'(CAPTURE_BYTES))) begin
         unique case (rel[3:0])
            4'd0:    act_in.sport[15:8] = a_byte_ff;
            4'd1:    act_in.sport[7:0] = a_byte_ff;
            4'd2:    act_in.dport[15:8] = a_byte_ff;
            4'd3:    act_in.dport[7:0] = a_byte_ff;
            4'd4:    act_in.seq[31:24] = a_byte_ff;
            4'd5:    act_in.seq[23:16] = a_byte_ff;
            4'd6:    act_in.seq[15:8] = a_byte_ff;
            4'd7:    act_in.seq[7:0] = a_byte_ff;
            4'd12:   act_in.tcp_off = a_byte_ff;
            4'd13:   act_in.tcp_flags = a_byte_ff;
            default: ;
         endcase
      end

      if (!idx_ff[0]) begin
         act_in.hold = a_byte_ff;
      end else if ((word_at < 16'(hdr_cur)) && (word_at != CHECKSUM_WORD)) begin
         act_in.sum = act_ff.sum + 21'({act_ff.hold, a_byte_ff});
      end
   end

   ihc_verdict u_verdict (
      .state  (snap_ff),
      .length (snap_len_ff),
      .result (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         idx_ff <= '0;
         act_ff <= '0;
         snap_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            a_valid_ff <= req_tvalid;
         end
         if (a_adv) begin
            if (a_last_ff) begin
               idx_ff <= '0;
               act_ff <= '0;
            end else begin
               idx_ff <= idx_in;
               act_ff <= act_in;
            end
         end
         if (snap_free) begin
            snap_valid_ff <= a_adv && a_last_ff;
         end
         if (out_free) begin
            out_valid_ff <= snap_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_byte_ff <= req_tdata;
         a_last_ff <= req_tlast;
      end
      if (a_adv && a_last_ff) begin
         snap_ff <= act_in;
         snap_len_ff <= idx_in;
      end
      if (out_free) begin
         out_ff <= verdict;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {(RSP_TDATA_W - $bits(result_type))'(0), out_ff};

endmodule

`default_nettype wire

[rtl/core/ihc_checker.sv]
// Port-level assertions for the IPv4/TCP/UDP header checker, bound to the
// top level. Depends on the port layout of ipv4_tcp_udp_header_checker.
`default_nettype none

module ihc_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [175:0] rsp_tdata
);

   // No verdict is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("verdict offered right after reset");

   // A stalled verdict holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled verdict changed");

   // A failed packet reports nothing but zeros.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[175:1] == 175'd0)
      else $error("failed verdict carries nonzero fields");

   // TCP flags and sequence stay zero for every protocol other than TCP.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8:1] != 8'd6 |-> rsp_tdata[169:134] == 36'd0)
      else $error("TCP fields set on a non-TCP verdict");

   // A passed packet always has a nonzero IP header length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[14:9] != 6'd0)
      else $error("passed verdict with zero header length");

endmodule

bind ipv4_tcp_udp_header_checker ihc_checker u_ihc_checker (.*);

`default_nettype wire

[test/header_verdict_checker.sv]
`timescale 1ns / 100ps
// Verdict checker for the IPv4/TCP/UDP header checker: watches the byte and
// verdict streams, predicts each verdict and compares it field by field. Uses ihc_pkg.

module header_verdict_checker #(
   parameter int CAPTURE_BYTES = 80
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [ihc_pkg::REQ_TDATA_W-1:0] req_tdata,  // data_byte[7:0]
   input  logic                            req_tlast,  // last_byte
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ihc_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // packed result_type, zeros above
   output int unsigned                     verdicts_pending,
   output int unsigned                     fail_count
);

   import ihc_pkg::*;

   localparam int IDX_W = $clog2(CAPTURE_BYTES);

   logic [15:0] byte_index;
   logic [7:0]  header_bytes [CAPTURE_BYTES];
   logic [20:0] word_sum;
   logic [7:0]  high_byte;
   result_type  expected_verdicts [$];
   int unsigned failures;
   int unsigned reports;

   function automatic logic [7:0] cap_byte(input logic [31:0] idx);
      return (idx < CAPTURE_BYTES) ? header_bytes[idx[IDX_W-1:0]] : 8'h00;
   endfunction

   function automatic logic [15:0] cap_word(input logic [31:0] idx);
      return {cap_byte(idx), cap_byte(idx + 1)};
   endfunction

   function automatic result_type judge_packet(input logic [31:0] length);
      result_type  v;
      logic [31:0] ihl_bytes, folded, kept, tp_bytes, udp_len;
      logic [15:0] frag_word;
      logic [7:0]  proto, offset_byte, flag_byte;
      v = '0;
      ihl_bytes = header_bytes[0][3:0] * 4;
      if (length < MIN_IP_BYTES || header_bytes[0][7:4] != IP_VERSION_4 ||
          ihl_bytes == 0 || ihl_bytes > length)
         return v;
      folded = 32'(word_sum);
      while (folded > 32'hFFFF)
         folded = (folded & 32'hFFFF) + (folded >> 16);
      folded = folded ^ 32'hFFFF;
      if (cap_word(32'(CHECKSUM_WORD)) != folded)
         return v;
      kept = length;
      if (cap_word(2) < kept)
         kept = 32'(cap_word(2));
      proto = cap_byte(9);
      tp_bytes = 0;
      if (proto == PROTO_TCP) begin
         if (kept < ihl_bytes + MIN_TCP_BYTES)
            return v;
         offset_byte = cap_byte(ihl_bytes + 12);
         tp_bytes = offset_byte[7:4] * 4;
         if (kept < ihl_bytes + tp_bytes || tp_bytes < MIN_TCP_BYTES)
            return v;
         v.source_port = cap_word(ihl_bytes);
         v.dest_port = cap_word(ihl_bytes + 2);
         v.tcp_sequence = {cap_word(ihl_bytes + 4), cap_word(ihl_bytes + 6)};
         flag_byte = cap_byte(ihl_bytes + 13);
         v.tcp_flag_bits = {flag_byte[4], flag_byte[2:0]};
      end else if (proto == PROTO_UDP) begin
         if (kept < ihl_bytes + UDP_HDR_BYTES)
            return v;
         udp_len = 32'(cap_word(ihl_bytes + 4));
         if (kept < ihl_bytes + udp_len)
            return v;
         kept = ihl_bytes + udp_len;
         tp_bytes = UDP_HDR_BYTES;
         v.source_port = cap_word(ihl_bytes);
         v.dest_port = cap_word(ihl_bytes + 2);
      end
      frag_word = cap_word(6);
      v.packet_ok = 1'b1;
      v.protocol_number = proto;
      v.ip_header_bytes = ihl_bytes[5:0];
      v.transport_header_bytes = tp_bytes[5:0];
      v.packet_bytes = kept[15:0];
      v.source_address = {cap_word(12), cap_word(14)};
      v.dest_address = {cap_word(16), cap_word(18)};
      v.is_fragment = frag_word[13] | (frag_word[12:0] != 13'd0);
      return v;
   endfunction

   task automatic show_verdict(input string tag, input result_type v);
      $display("%s ok=%0d proto=%0d ip_hdr=%0d tp_hdr=%0d bytes=%0d", tag, v.packet_ok,
               v.protocol_number, v.ip_header_bytes, v.transport_header_bytes,
               v.packet_bytes);
      $display("%s src=%h dst=%h sport=%0d dport=%0d frag=%0d flags=%h seq=%h", tag,
               v.source_address, v.dest_address, v.source_port, v.dest_port,
               v.is_fragment, v.tcp_flag_bits, v.tcp_sequence);
   endtask

   always @(posedge clock) begin : watch
      result_type  want, got;
      logic [31:0] idx, length;
      if (reset) begin
         byte_index = '0;
         word_sum = '0;
         high_byte = '0;
         expected_verdicts.delete();
         failures = 0;
         reports = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(result_type)-1:0];
            if (expected_verdicts.size() == 0) begin
               failures++;
               if (reports < 10) begin
                  $display("%0t: verdict transaction with none expected", $time);
                  show_verdict("  actual  ", got);
               end
               reports++;
            end else begin
               want = expected_verdicts.pop_front();
               if (got.packet_ok !== want.packet_ok ||
                   got.protocol_number !== want.protocol_number ||
                   got.ip_header_bytes !== want.ip_header_bytes ||
                   got.transport_header_bytes !== want.transport_header_bytes ||
                   got.packet_bytes !== want.packet_bytes ||
                   got.source_address !== want.source_address ||
                   got.dest_address !== want.dest_address ||
                   got.source_port !== want.source_port ||
                   got.dest_port !== want.dest_port ||
                   got.is_fragment !== want.is_fragment ||
                   got.tcp_flag_bits !== want.tcp_flag_bits ||
                   got.tcp_sequence !== want.tcp_sequence ||
                   rsp_tdata[RSP_TDATA_W-1:$bits(result_type)] !== '0) begin
                  failures++;
                  if (reports < 10) begin
                     $display("%0t: verdict mismatch", $time);
                     show_verdict("  expected", want);
                     show_verdict("  actual  ", got);
                  end
                  reports++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            idx = 32'(byte_index);
            if (idx < CAPTURE_BYTES)
               header_bytes[idx[IDX_W-1:0]] = req_tdata;
            if (!idx[0])
               high_byte = req_tdata;
            else if (idx - 1 < header_bytes[0][3:0] * 4 && idx - 1 != CHECKSUM_WORD)
               word_sum = word_sum + {high_byte, req_tdata};
            length = (idx == 32'hFFFF) ? idx : idx + 1;
            if (req_tlast) begin
               expected_verdicts.push_back(judge_packet(length));
               byte_index = '0;
               word_sum = '0;
               high_byte = '0;
            end else begin
               byte_index = length[15:0];
            end
         end
      end
      verdicts_pending <= expected_verdicts.size();
      fail_count <= failures;
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the header checker testbench: clock, reset, packet stimulus with random
// idling on both streams, and the final verdict. Uses ihc_pkg and header_verdict_checker.

module testbench;

   import ihc_pkg::*;

   localparam logic [7:0] PROTO_ICMP = 8'd1;

   typedef enum int unsigned {FLIP_BIT, TRUNCATE, BAD_VERSION, ZERO_IHL} damage_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_hold;
   logic                   hold_go;
   int unsigned            verdicts_pending;
   int unsigned            fail_count;
   logic [7:0]             packet [$];

   always #5 clock = ~clock;

   ipv4_tcp_udp_header_checker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   header_verdict_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .verdicts_pending (verdicts_pending),
      .fail_count       (fail_count)
   );

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) < 9)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic seal_checksum();
      logic [31:0] acc, hdr;
      hdr = packet[0][3:0] * 4;
      acc = 0;
      for (int w = 0; w + 1 < hdr; w += 2)
         if (w != CHECKSUM_WORD)
            acc = acc + {packet[w], packet[w + 1]};
      while (acc > 32'hFFFF)
         acc = (acc & 32'hFFFF) + (acc >> 16);
      packet[10] = ~acc[15:8];
      packet[11] = ~acc[7:0];
   endtask

   task automatic cut_packet(input int unsigned n);
      while (packet.size() > n)
         void'(packet.pop_back());
   endtask

   task automatic fill_packet(input int unsigned n, input logic [7:0] value);
      packet.delete();
      repeat (n) packet.push_back(value);
   endtask

   // For TCP the field is the data offset, for UDP the UDP length.
   task automatic build_packet(input logic [3:0] ihl, input logic [7:0] proto,
                               input logic [31:0] field, input int unsigned payload,
                               input int unsigned tail, input int delta);
      int unsigned       hdr, region, n;
      logic signed [31:0] total;
      logic [15:0]       frag;
      int unsigned       roll;
      hdr = ihl * 4;
      region = 0;
      if (proto == PROTO_TCP)
         region = (field * 4 > MIN_TCP_BYTES) ? field * 4 : MIN_TCP_BYTES;
      else if (proto == PROTO_UDP)
         region = UDP_HDR_BYTES;
      if (hdr + region + payload < MIN_IP_BYTES)
         payload = MIN_IP_BYTES - hdr - region;
      n = hdr + region + payload + tail;
      total = hdr + region + payload + delta;
      if (total < 0)
         total = 0;
      if (total > 65535)
         total = 65535;
      roll = $urandom_range(0, 9);
      frag = (roll < 7) ? 16'h0000 : ((roll < 8) ? 16'h4000 : 16'($urandom_range(0, 65535)));
      packet.delete();
      for (int i = 0; i < n; i++)
         packet.push_back(8'($urandom_range(0, 255)));
      packet[0] = {IP_VERSION_4, ihl};
      packet[2] = total[15:8];
      packet[3] = total[7:0];
      packet[6] = frag[15:8];
      packet[7] = frag[7:0];
      packet[9] = proto;
      if (proto == PROTO_TCP) begin
         packet[hdr + 12] = {field[3:0], packet[hdr + 12][3:0]};
      end else if (proto == PROTO_UDP) begin
         packet[hdr + 4] = field[15:8];
         packet[hdr + 5] = field[7:0];
      end
      seal_checksum();
   endtask

   task automatic random_packet();
      logic [3:0]  ihl, nib;
      logic [7:0]  proto;
      logic [31:0] field;
      int unsigned roll, payload, tail, pos;
      int          delta;
      damage_type  damage;
      roll = $urandom_range(0, 99);
      ihl = (roll < 85) ? 4'd5 :
            ((roll < 97) ? 4'($urandom_range(6, 15)) : 4'($urandom_range(1, 4)));
      payload = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
      tail = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 10) : 0;
      roll = $urandom_range(0, 99);
      if (roll < 75)
         delta = 0;
      else if (roll < 85)
         delta = -int'($urandom_range(1, 30));
      else
         delta = int'($urandom_range(1, 30));
      roll = $urandom_range(0, 99);
      if (ihl < 5 || roll >= 75) begin
         proto = 8'($urandom_range(0, 255));
         field = 0;
      end else if (roll < 40) begin
         proto = PROTO_TCP;
         field = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
      end else begin
         proto = PROTO_UDP;
         roll = $urandom_range(0, 99);
         if (roll < 85)
            field = UDP_HDR_BYTES + payload;
         else if (roll < 95)
            field = $urandom_range(0, 7);
         else
            field = $urandom_range(0, 65535);
      end
      build_packet(ihl, proto, field, payload, tail, delta);
      if ($urandom_range(0, 99) < 15) begin
         damage = damage_type'($urandom_range(0, 3));
         case (damage)
            FLIP_BIT: begin
               pos = $urandom_range(0, packet.size() - 1);
               packet[pos] = packet[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            TRUNCATE: cut_packet($urandom_range(1, packet.size()));
            BAD_VERSION: begin
               nib = 4'($urandom_range(0, 15));
               packet[0] = {nib, packet[0][3:0]};
            end
            ZERO_IHL: packet[0] = {packet[0][7:4], 4'h0};
         endcase
      end
   endtask

   task automatic send_packet(input logic steady);
      int unsigned gap;
      for (int i = 0; i < packet.size(); i++) begin
         gap = 0;
         if (!steady && $urandom_range(0, 99) < 25)
            gap = pick_gap();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= packet[i];
         req_tlast <= (i == packet.size() - 1);
         do @(posedge clock); while (!req_tready);
      end
   endtask

   task automatic drain_verdicts();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
   endtask

   initial begin : rsp_side
      int unsigned stall, calm;
      stall = 0;
      calm = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (calm > 0) begin
            rsp_tready <= 1'b1;
            calm--;
         end else if ($urandom_range(0, 99) < 30) begin
            rsp_tready <= 1'b0;
            stall = pick_gap() - 1;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < 3)
               calm = $urandom_range(30, 150);
         end
      end
   end

   initial begin : rsp_hold_off
      rsp_hold <= 1'b0;
      @(posedge hold_go);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int unsigned random_bytes, random_packets;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      hold_go <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      build_packet(4'd5, PROTO_ICMP, 0, 0, 0, 0);
      send_packet(1'b0);
      build_packet(4'd5, PROTO_TCP, 5, 0, 0, 0);
      send_packet(1'b0);
      build_packet(4'd5, PROTO_UDP, 8, 0, 0, 0);
      send_packet(1'b0);
      build_packet(4'd15, PROTO_TCP, 15, 10, 0, 0);
      send_packet(1'b0);
      build_packet(4'd5, PROTO_UDP, 3, 0, 0, 0);
      send_packet(1'b0);
      build_packet(4'd5, PROTO_UDP, 12, 4, 6, 6);
      send_packet(1'b0);
      build_packet(4'd5, PROTO_ICMP, 0, 10, 0, -5);
      send_packet(1'b0);
      build_packet(4'd5, PROTO_TCP, 5, 4, 0, 20);
      send_packet(1'b0);
      build_packet(4'd1, PROTO_ICMP, 0, 16, 0, 0);
      send_packet(1'b0);
      build_packet(4'd5, PROTO_TCP, 4, 0, 0, 0);
      send_packet(1'b0);
      build_packet(4'd5, PROTO_TCP, 8, 0, 0, 0);
      cut_packet(45);
      send_packet(1'b0);
      build_packet(4'd5, PROTO_UDP, 200, 0, 0, 0);
      send_packet(1'b0);
      build_packet(4'd5, PROTO_ICMP, 0, 0, 0, 0);
      packet[6] = 8'h20;
      packet[7] = 8'h00;
      seal_checksum();
      send_packet(1'b0);
      build_packet(4'd5, PROTO_ICMP, 0, 0, 0, 0);
      packet[6] = 8'h00;
      packet[7] = 8'h01;
      seal_checksum();
      send_packet(1'b0);
      build_packet(4'd5, PROTO_ICMP, 0, 0, 0, 0);
      packet[0] = 8'h40;
      send_packet(1'b0);
      build_packet(4'd5, PROTO_ICMP, 0, 0, 0, 0);
      packet[0] = 8'h65;
      send_packet(1'b0);
      build_packet(4'd5, PROTO_TCP, 5, 8, 0, 0);
      packet[10] = packet[10] ^ 8'h80;
      send_packet(1'b0);
      build_packet(4'd5, PROTO_ICMP, 0, 10, 0, 0);
      cut_packet(19);
      send_packet(1'b0);
      build_packet(4'd5, PROTO_ICMP, 0, 0, 0, 0);
      cut_packet(1);
      send_packet(1'b0);
      build_packet(4'd15, PROTO_ICMP, 0, 0, 0, 0);
      cut_packet(40);
      send_packet(1'b0);
      fill_packet(20, 8'hFF);
      send_packet(1'b0);
      fill_packet(20, 8'h00);
      send_packet(1'b0);
      // A packet longer than the byte counter can count.
      build_packet(4'd5, PROTO_ICMP, 0, 65520, 0, 0);
      send_packet(1'b1);
      drain_verdicts();

      hold_go <= 1'b1;
      random_bytes = 0;
      random_packets = 0;
      while (random_bytes < 1500 || random_packets < 60) begin
         random_packet();
         random_bytes += packet.size();
         random_packets++;
         send_packet($urandom_range(0, 4) == 0);
         if (random_packets == 40)
            drain_verdicts();
      end
      drain_verdicts();
      repeat (20) @(posedge clock);

      if (fail_count == 0 && verdicts_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
